>>> rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit sequencer core.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Command codes carried in the operation field.
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_SEND  = 3'd2;
   localparam logic [2:0] OP_WAIT  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Tick counts for each phase of a command.
   localparam logic [2:0] DLY_START_SETUP = 3'd5;
   localparam logic [2:0] DLY_HOLD        = 3'd6;
   localparam logic [2:0] DLY_BIT         = 3'd2;
   localparam logic [2:0] DLY_ACK_POLL    = 3'd1;
   localparam logic [2:0] DLY_ACK_HIGH    = 3'd5;
   localparam logic [2:0] DLY_RX_HIGH     = 3'd1;

   localparam logic [7:0] RESET_TIMEOUT = 8'd250;
   localparam logic [7:0] POLL_MAX      = 8'hFF;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [14:0] {
      ST_IDLE = 15'b000000000000001,
      ST_ST_A = 15'b000000000000010,
      ST_ST_B = 15'b000000000000100,
      ST_SP_A = 15'b000000000001000,
      ST_SP_B = 15'b000000000010000,
      ST_TX_D = 15'b000000000100000,
      ST_TX_H = 15'b000000001000000,
      ST_TX_L = 15'b000000010000000,
      ST_WA_A = 15'b000000100000000,
      ST_WA_B = 15'b000001000000000,
      ST_WA_P = 15'b000010000000000,
      ST_RX_L = 15'b000100000000000,
      ST_RX_H = 15'b001000000000000,
      ST_AK_A = 15'b010000000000000,
      ST_AK_B = 15'b100000000000000
   } step_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] operation;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_level;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_out_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } result_type;

endpackage

>>> rtl/core/i2cm_req_if.sv
// ----------------------------------------------------------------------------
// i2cm_req_if
// Command channel: one word per delay tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] operation;
   logic [7:0] write_data;
   logic       send_ack;
   logic       sda_level;

   modport source (output valid, cmd_valid, operation, write_data, send_ack, sda_level,
                   input ready);
   modport sink   (input valid, cmd_valid, operation, write_data, send_ack, sda_level,
                   output ready);
endinterface

>>> rtl/core/i2cm_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Result channel: pin levels and status, one word per tick.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_out_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       ack_missing;

   modport source (output valid, scl_level, sda_out_level, sda_drive, busy_res, done_res,
                   read_data, ack_missing, input ready);
   modport sink   (input valid, scl_level, sda_out_level, sda_drive, busy_res, done_res,
                   read_data, ack_missing, output ready);
endinterface

>>> rtl/core/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bit sequencer state and its one-tick update, plus the timeout register.
// ----------------------------------------------------------------------------
module i2cm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cm_pkg::item_type  item,
   input  logic                csr_we,
   input  logic [7:0]          csr_wdata,
   output i2cm_pkg::result_type result
);

   i2cm_pkg::step_type step_ff, step_in;
   logic [2:0] delay_ff, delay_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] poll_ff, poll_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       drive_ff, drive_in;
   logic       timeout_ff, timeout_in;
   logic [7:0] rd_byte_ff, rd_byte_in;
   logic [7:0] timeout_polls_ff;
   logic       done;

   always_comb begin
      logic [2:0] dly;
      logic [3:0] bi;
      logic [7:0] pc;
      step_in       = step_ff;
      delay_in      = delay_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      poll_in       = poll_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      timeout_in    = timeout_ff;
      rd_byte_in    = rd_byte_ff;
      done          = 1'b0;
      dly           = delay_ff - 3'd1;
      bi            = bit_ff + 4'd1;
      pc            = (poll_ff != i2cm_pkg::POLL_MAX) ? poll_ff + 8'd1 : poll_ff;

      unique case (step_ff)
         i2cm_pkg::ST_IDLE: begin
            if (item.cmd_valid) begin
               unique case (item.operation)
                  i2cm_pkg::OP_START: begin
                     bit_in   = '0;
                     drive_in = 1'b1;
                     sda_in   = 1'b1;
                     scl_in   = 1'b1;
                     step_in  = i2cm_pkg::ST_ST_A;
                     delay_in = i2cm_pkg::DLY_START_SETUP;
                  end
                  i2cm_pkg::OP_STOP: begin
                     bit_in   = '0;
                     drive_in = 1'b1;
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                     step_in  = i2cm_pkg::ST_SP_A;
                     delay_in = i2cm_pkg::DLY_HOLD;
                  end
                  i2cm_pkg::OP_SEND: begin
                     bit_in   = '0;
                     drive_in = 1'b1;
                     scl_in   = 1'b0;
                     sda_in   = item.write_data[7];
                     shift_in = {item.write_data[6:0], 1'b0};
                     step_in  = i2cm_pkg::ST_TX_D;
                     delay_in = i2cm_pkg::DLY_BIT;
                  end
                  i2cm_pkg::OP_WAIT: begin
                     bit_in     = '0;
                     poll_in    = '0;
                     timeout_in = 1'b0;
                     drive_in   = 1'b0;
                     sda_in     = 1'b1;
                     step_in    = i2cm_pkg::ST_WA_A;
                     delay_in   = i2cm_pkg::DLY_ACK_POLL;
                  end
                  i2cm_pkg::OP_READ: begin
                     bit_in        = '0;
                     ack_choice_in = item.send_ack;
                     shift_in      = '0;
                     drive_in      = 1'b0;
                     scl_in        = 1'b0;
                     step_in       = i2cm_pkg::ST_RX_L;
                     delay_in      = i2cm_pkg::DLY_BIT;
                  end
                  default: begin
                     // Undefined codes leave the block idle.
                  end
               endcase
            end
         end
         i2cm_pkg::ST_WA_P: begin
            delay_in = '0;
            if (!item.sda_level) begin
               scl_in  = 1'b0;
               step_in = i2cm_pkg::ST_IDLE;
               done    = 1'b1;
            end else begin
               poll_in = pc;
               if (pc > timeout_polls_ff) begin
                  timeout_in = 1'b1;
                  drive_in   = 1'b1;
                  scl_in     = 1'b1;
                  sda_in     = 1'b0;
                  step_in    = i2cm_pkg::ST_SP_A;
                  delay_in   = i2cm_pkg::DLY_HOLD;
               end
            end
         end
         default: begin
            delay_in = dly;
            if (dly == 3'd0) begin
               unique case (step_ff)
                  i2cm_pkg::ST_ST_A: begin
                     sda_in   = 1'b0;
                     step_in  = i2cm_pkg::ST_ST_B;
                     delay_in = i2cm_pkg::DLY_HOLD;
                  end
                  i2cm_pkg::ST_ST_B: begin
                     scl_in  = 1'b0;
                     step_in = i2cm_pkg::ST_IDLE;
                     done    = 1'b1;
                  end
                  i2cm_pkg::ST_SP_A: begin
                     sda_in   = 1'b1;
                     step_in  = i2cm_pkg::ST_SP_B;
                     delay_in = i2cm_pkg::DLY_HOLD;
                  end
                  i2cm_pkg::ST_SP_B: begin
                     step_in = i2cm_pkg::ST_IDLE;
                     done    = 1'b1;
                  end
                  i2cm_pkg::ST_TX_D: begin
                     scl_in   = 1'b1;
                     step_in  = i2cm_pkg::ST_TX_H;
                     delay_in = i2cm_pkg::DLY_BIT;
                  end
                  i2cm_pkg::ST_TX_H: begin
                     scl_in   = 1'b0;
                     step_in  = i2cm_pkg::ST_TX_L;
                     delay_in = i2cm_pkg::DLY_BIT;
                  end
                  i2cm_pkg::ST_TX_L: begin
                     bit_in = bi;
                     if (bi >= i2cm_pkg::BITS_PER_BYTE) begin
                        step_in = i2cm_pkg::ST_IDLE;
                        done    = 1'b1;
                     end else begin
                        drive_in = 1'b1;
                        scl_in   = 1'b0;
                        sda_in   = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0};
                        step_in  = i2cm_pkg::ST_TX_D;
                        delay_in = i2cm_pkg::DLY_BIT;
                     end
                  end
                  i2cm_pkg::ST_WA_A: begin
                     scl_in   = 1'b1;
                     step_in  = i2cm_pkg::ST_WA_B;
                     delay_in = i2cm_pkg::DLY_ACK_POLL;
                  end
                  i2cm_pkg::ST_WA_B: begin
                     // The first poll falls on the tick the SCL-high wait ends.
                     step_in = i2cm_pkg::ST_WA_P;
                     if (!item.sda_level) begin
                        scl_in  = 1'b0;
                        step_in = i2cm_pkg::ST_IDLE;
                        done    = 1'b1;
                     end else begin
                        poll_in = pc;
                        if (pc > timeout_polls_ff) begin
                           timeout_in = 1'b1;
                           drive_in   = 1'b1;
                           scl_in     = 1'b1;
                           sda_in     = 1'b0;
                           step_in    = i2cm_pkg::ST_SP_A;
                           delay_in   = i2cm_pkg::DLY_HOLD;
                        end
                     end
                  end
                  i2cm_pkg::ST_RX_L: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[6:0], item.sda_level};
                     step_in  = i2cm_pkg::ST_RX_H;
                     delay_in = i2cm_pkg::DLY_RX_HIGH;
                  end
                  i2cm_pkg::ST_RX_H: begin
                     bit_in = bi;
                     if (bi >= i2cm_pkg::BITS_PER_BYTE) begin
                        rd_byte_in = shift_ff;
                        scl_in     = 1'b0;
                        drive_in   = 1'b1;
                        sda_in     = ~ack_choice_ff;
                        step_in    = i2cm_pkg::ST_AK_A;
                        delay_in   = i2cm_pkg::DLY_BIT;
                     end else begin
                        drive_in = 1'b0;
                        scl_in   = 1'b0;
                        step_in  = i2cm_pkg::ST_RX_L;
                        delay_in = i2cm_pkg::DLY_BIT;
                     end
                  end
                  i2cm_pkg::ST_AK_A: begin
                     scl_in   = 1'b1;
                     step_in  = i2cm_pkg::ST_AK_B;
                     delay_in = i2cm_pkg::DLY_ACK_HIGH;
                  end
                  i2cm_pkg::ST_AK_B: begin
                     scl_in  = 1'b0;
                     step_in = i2cm_pkg::ST_IDLE;
                     done    = 1'b1;
                  end
                  default: begin
                     step_in  = i2cm_pkg::ST_IDLE;
                     delay_in = '0;
                  end
               endcase
            end
         end
      endcase

      if (step_in == i2cm_pkg::ST_IDLE) begin
         delay_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= i2cm_pkg::ST_IDLE;
         delay_ff         <= '0;
         bit_ff           <= '0;
         shift_ff         <= '0;
         poll_ff          <= '0;
         ack_choice_ff    <= 1'b0;
         scl_ff           <= 1'b1;
         sda_ff           <= 1'b1;
         drive_ff         <= 1'b1;
         timeout_ff       <= 1'b0;
         rd_byte_ff       <= '0;
         timeout_polls_ff <= i2cm_pkg::RESET_TIMEOUT;
      end else begin
         if (csr_we) begin
            timeout_polls_ff <= csr_wdata;
         end
         if (step_en) begin
            step_ff       <= step_in;
            delay_ff      <= delay_in;
            bit_ff        <= bit_in;
            shift_ff      <= shift_in;
            poll_ff       <= poll_in;
            ack_choice_ff <= ack_choice_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            drive_ff      <= drive_in;
            timeout_ff    <= timeout_in;
            rd_byte_ff    <= rd_byte_in;
         end
      end
   end

   assign result.scl_level     = scl_in;
   assign result.sda_out_level = sda_in;
   assign result.sda_drive     = drive_in;
   assign result.busy_res      = (step_in != i2cm_pkg::ST_IDLE);
   assign result.done_res      = done;
   assign result.read_data     = rd_byte_in;
   assign result.ack_missing   = timeout_in;

endmodule

>>> rtl/core/i2c_master_bit_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master that steps its SCL/SDA phases by one delay tick per command word.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Contents
//   req_port  in         valid/ready    command, data byte, ACK choice, SDA sample
//   rsp_port  out        valid/ready    SCL/SDA levels, drive, status, read byte
//   csr_*     in         write enable   ACK timeout poll count
//
// An accepted word moves from the input register into the result register;
// the short sequencer update between the two registers lets a new word in
// every cycle while the result channel takes words. Synchronous reset
// idles the sequencer with both lines high and SDA driven, sets the timeout
// to 250 and empties both registers. A stalled result channel holds the
// result register, and the input register then fills and drops ready.
//
module i2c_master_bit_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_port,
   i2cm_rsp_if.source  rsp_port,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   // The input register holds one accepted word until the sequencer takes it.
   logic                 in_valid_ff, in_valid_in;
   i2cm_pkg::item_type   in_item_ff;

   // The result register holds one finished word until the sink takes it.
   logic                 out_valid_ff, out_valid_in;
   i2cm_pkg::result_type out_res_ff;
   i2cm_pkg::result_type seq_res;

   logic                 step_en;
   logic                 in_load;

   // The sequencer advances one tick whenever a word is waiting and the
   // result register is empty or being emptied in this cycle.
   assign step_en = in_valid_ff && (!out_valid_ff || rsp_port.ready);

   // The input register may reload when empty or when its word moves on.
   assign req_port.ready = !in_valid_ff || step_en;
   assign in_load        = req_port.valid && req_port.ready;

   assign in_valid_in  = in_load || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff.cmd_valid  <= req_port.cmd_valid;
         in_item_ff.operation  <= req_port.operation;
         in_item_ff.write_data <= req_port.write_data;
         in_item_ff.send_ack   <= req_port.send_ack;
         in_item_ff.sda_level  <= req_port.sda_level;
      end
      if (step_en) begin
         out_res_ff <= seq_res;
      end
   end

   // The sequencer holds all command state and computes the pins and status
   // that follow this tick.
   i2cm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .item      (in_item_ff),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (seq_res)
   );

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.scl_level     = out_res_ff.scl_level;
   assign rsp_port.sda_out_level = out_res_ff.sda_out_level;
   assign rsp_port.sda_drive     = out_res_ff.sda_drive;
   assign rsp_port.busy_res      = out_res_ff.busy_res;
   assign rsp_port.done_res      = out_res_ff.done_res;
   assign rsp_port.read_data     = out_res_ff.read_data;
   assign rsp_port.ack_missing   = out_res_ff.ack_missing;

endmodule
